// File: src/prime_sieve_engine_assert.svh
// assertion macros shared by the prime sieve checker
// depends on a clk and an active-high rst in the scope of use
`ifndef PRIME_SIEVE_ENGINE_ASSERT_SVH
`define PRIME_SIEVE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication that is also checked while reset is high
`define PSE_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/pse_pkg.sv
// shared types and constants of the prime sieve engine
// no dependencies
package pse_pkg;

  localparam int NUM_W = 12;

  // func codes of a request word
  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // reset value of the limit register
  localparam logic [NUM_W-1:0] LIMIT_RESET = 12'd100;

  // smallest prime, first candidate of the sieve
  localparam logic [NUM_W-1:0] FIRST_PRIME = 12'd2;

  // entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic             func;
    logic [NUM_W-1:0] query_value;
  } req_t;

  typedef struct packed {
    logic             is_prime;
    logic [NUM_W-1:0] prime_count;
    logic [NUM_W-1:0] largest_prime;
    logic             table_ready;
  } rsp_t;

  // classified command: build carries the clamped limit, query the number
  typedef struct packed {
    logic             is_build;
    logic [NUM_W-1:0] value;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// File: src/pse_ram.sv
// generic single-port ram with registered read
// no dependencies
module pse_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data valid the cycle after re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/pse_front.sv
// front end: limit register, request classification and command queue
// depends on pse_pkg
module pse_front #(
  parameter int MAX_NUMBER = 4095
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  pse_pkg::req_t          req_data,
  input  logic                   cfg_wen,
  input  logic [pse_pkg::NUM_W-1:0] cfg_wdata,
  output pse_pkg::q_head_t       head,
  input  logic                   pop
);

  localparam int PW = $clog2(pse_pkg::QUEUE_DEPTH);

  logic [pse_pkg::NUM_W-1:0] upper_limit;
  logic [pse_pkg::NUM_W-1:0] lim_clamped;
  pse_pkg::cmd_t             cmd_in;
  pse_pkg::cmd_t             entry [pse_pkg::QUEUE_DEPTH];
  logic [PW-1:0]             wr_ptr;
  logic [PW-1:0]             rd_ptr;
  logic [PW:0]               fill;
  logic                      push;
  logic                      do_pop;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= pse_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      upper_limit <= cfg_wdata;
    end
  end

  // clamp the limit to the map size
  always_comb begin
    if ({9'd0, upper_limit} > 21'(MAX_NUMBER)) begin
      lim_clamped = pse_pkg::NUM_W'(MAX_NUMBER);
    end else begin
      lim_clamped = upper_limit;
    end
  end

  // classify the incoming word
  always_comb begin
    cmd_in.is_build = (req_data.func == pse_pkg::FUNC_BUILD);
    cmd_in.value    = cmd_in.is_build ? lim_clamped : req_data.query_value;
  end

  assign req_stall = (fill == (PW+1)'(pse_pkg::QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign do_pop    = pop && (fill != '0);

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (fill != '0);
  assign head.cmd   = entry[rd_ptr];

endmodule

// File: src/pse_back.sv
// back end: sieve sequencer over the prime map ram, query lookup, result register
// depends on pse_pkg and pse_ram
module pse_back #(
  parameter int MAX_NUMBER = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  pse_pkg::q_head_t head,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output pse_pkg::rsp_t    rsp_data
);

  localparam int DEPTH = MAX_NUMBER + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = pse_pkg::NUM_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_TST    = 10'b0000001000,
    S_MARK   = 10'b0000010000,
    S_CNT    = 10'b0000100000,
    S_CDR    = 10'b0001000000,
    S_COMMIT = 10'b0010000000,
    S_QRD    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t        state;
  state_t        state_next;

  logic [NW-1:0] lim;
  logic [NW-1:0] k;
  logic [6:0]    i;
  logic [12:0]   sq;
  logic [NW-1:0] j;
  logic          rv;
  logic [NW-1:0] rk;
  logic [NW-1:0] cnt;
  logic [NW-1:0] lgst;
  logic          built;
  logic [NW-1:0] stored_count;
  logic [NW-1:0] stored_largest;
  logic [NW-1:0] built_limit;
  logic          hit;
  logic          prime_r;

  logic [12:0]    j_sum;
  logic [12:0]    sq_step;
  logic           sq_over;
  logic           out_load;
  logic [NW-1:0]  addr12;
  logic [AW+NW-1:0] addr_ext;
  logic [AW-1:0]  ram_addr;
  logic           ram_we;
  logic           ram_re;
  logic           ram_wdata;
  logic           ram_rdata;

  assign j_sum    = {1'b0, j} + 13'(i);
  assign sq_step  = sq + 13'({i, 1'b0}) + 13'd1;
  assign sq_over  = sq > {1'b0, lim};
  assign pop      = (state == S_IDLE) && head.valid;
  assign out_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // ram port selection
  always_comb begin
    addr12    = k;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = 1'b0;
    unique case (state)
      S_IDLE: begin
        addr12 = head.cmd.value;
        ram_re = pop && !head.cmd.is_build;
      end
      S_INIT: begin
        addr12    = k;
        ram_we    = 1'b1;
        ram_wdata = (k >= pse_pkg::FIRST_PRIME);
      end
      S_CHK: begin
        addr12 = NW'(i);
        ram_re = !sq_over;
      end
      S_MARK: begin
        addr12 = j;
        ram_we = 1'b1;
      end
      S_CNT: begin
        addr12 = k;
        ram_re = 1'b1;
      end
      S_TST, S_CDR, S_COMMIT, S_QRD, S_DONE: begin
        addr12 = k;
      end
      default: begin
        addr12 = k;
      end
    endcase
  end

  assign addr_ext = {{AW{1'b0}}, addr12};
  assign ram_addr = addr_ext[AW-1:0];

  pse_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          state_next = head.cmd.is_build ? S_INIT : S_QRD;
        end
      end
      S_INIT: begin
        if (k == lim) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sq_over) begin
          state_next = (lim < pse_pkg::FIRST_PRIME) ? S_COMMIT : S_CNT;
        end else begin
          state_next = S_TST;
        end
      end
      S_TST: begin
        state_next = ram_rdata ? S_MARK : S_CHK;
      end
      S_MARK: begin
        if (j_sum > {1'b0, lim}) begin
          state_next = S_CHK;
        end
      end
      S_CNT: begin
        if (k == lim) begin
          state_next = S_CDR;
        end
      end
      S_CDR: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_DONE;
      end
      S_QRD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      built          <= 1'b0;
      stored_count   <= '0;
      stored_largest <= '0;
      built_limit    <= '0;
      rv             <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == S_CNT);
      if (state == S_COMMIT) begin
        built          <= 1'b1;
        stored_count   <= cnt;
        stored_largest <= lgst;
        built_limit    <= lim;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // sieve and lookup datapath
  always_ff @(posedge clk) begin
    rk <= k;
    case (state)
      S_IDLE: begin
        lim <= head.cmd.value;
        k   <= '0;
        hit <= built && (head.cmd.value >= pse_pkg::FIRST_PRIME) &&
               (head.cmd.value <= built_limit);
      end
      S_INIT: begin
        k  <= k + 1'b1;
        i  <= 7'(pse_pkg::FIRST_PRIME);
        sq <= 13'd4;
      end
      S_CHK: begin
        k    <= pse_pkg::FIRST_PRIME;
        cnt  <= '0;
        lgst <= '0;
      end
      S_TST: begin
        j <= sq[NW-1:0];
        if (!ram_rdata) begin
          i  <= i + 7'd1;
          sq <= sq_step;
        end
      end
      S_MARK: begin
        j <= j_sum[NW-1:0];
        if (j_sum > {1'b0, lim}) begin
          i  <= i + 7'd1;
          sq <= sq_step;
        end
      end
      S_CNT: begin
        k <= k + 1'b1;
      end
      S_COMMIT: begin
        prime_r <= 1'b0;
      end
      S_QRD: begin
        prime_r <= hit && ram_rdata;
      end
      default: begin
      end
    endcase
    // tally one map bit per cycle while counting
    if (rv && ram_rdata) begin
      if (cnt != '1) begin
        cnt <= cnt + 1'b1;
      end
      lgst <= rk;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_data.is_prime      <= prime_r;
      rsp_data.prime_count   <= stored_count;
      rsp_data.largest_prime <= stored_largest;
      rsp_data.table_ready   <= built;
    end
  end

endmodule

// File: src/prime_sieve_engine.sv
// query: queue, states IDLE, QRD, DONE; a later word pops once the result loads
// build: for limit L, INIT sets the map, CHK/TST test candidates, MARK clears
//   multiples, CNT counts; single-port prime map ram does one access a cycle
// queue holds two words, so up to two requests are taken while a result waits
// synchronous reset rst empties the queue, marks the table unbuilt, sets limit 100
module prime_sieve_engine #(
  parameter int MAX_NUMBER = 4095
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  pse_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pse_pkg::rsp_t             rsp_data,
  input  logic                      cfg_wen,
  input  logic [pse_pkg::NUM_W-1:0] cfg_wdata
);

  pse_pkg::q_head_t head;
  logic             pop;

  // request side
  pse_front #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop)
  );

  // sieve and lookup side
  pse_back #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// File: src/pse_checker.sv
// port-level checks for the prime sieve engine, bound to the top level
// depends on pse_pkg and prime_sieve_engine_assert.svh
`include "prime_sieve_engine_assert.svh"

module pse_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pse_pkg::rsp_t rsp_data
);

  // a stalled result word holds
  `PSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result word changed while stalled")

  // before any build everything reads zero
  `PSE_ASSERT_NOW(a_not_built, rsp_valid && !rsp_data.table_ready, !rsp_data.is_prime && rsp_data.prime_count == '0 && rsp_data.largest_prime == '0, "nonzero result before a build")

  // a prime hit implies a built table with at least one prime
  `PSE_ASSERT_NOW(a_hit_built, rsp_valid && rsp_data.is_prime, rsp_data.table_ready && rsp_data.prime_count != '0 && rsp_data.largest_prime != '0, "prime reported without a built table")

  // right after reset no result is shown and the queue takes words
  `PSE_ASSERT_ALWAYS(a_reset_clear, !rst && $past(rst), !rsp_valid && !req_stall, "state not cleared by reset")

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (.*);
